FILE: hdl/tsfe_pkg.sv
// Shared types, constants and arithmetic helpers for the tabulated spline evaluator.
// No dependencies; every other file of the block imports this package.
package tsfe_pkg;

  // Parameter defaults
  localparam int DEF_MAX_TABLES = 4;
  localparam int DEF_MAX_POINTS = 1024;
  localparam int DEF_MAX_TYPES  = 4;

  // Fixed field widths
  localparam int DATA_W  = 32;
  localparam int ARG_W   = 31;
  localparam int FRAC_W  = 17;
  localparam int CNT_W   = 11;
  localparam int TAB_W   = 2;
  localparam int TYPE_W  = 2;
  localparam int PT_W    = 11;
  localparam int SLOT_W  = 3;
  localparam int CMD_W   = 2;
  localparam int NCOEF   = 7;
  localparam int PADDR_W = 4;
  localparam int PROD_W  = 2 * ARG_W;

  // 1.0 in Q16.16
  localparam logic [FRAC_W-1:0] ONE_Q = FRAC_W'(65536);

  // Register reset values
  localparam logic [ARG_W-1:0] INV_STEP_RST    = ARG_W'(65536);
  localparam logic [CNT_W-1:0] POINT_COUNT_RST = CNT_W'(1024);
  localparam logic [ARG_W-1:0] ARG_MAX_RST     = '0;

  // Saturation bounds
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  typedef enum logic [CMD_W-1:0] {
    CMD_WCOEF = 2'd0,
    CMD_WMAP  = 2'd1,
    CMD_EVAL  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_INV_STEP    = 2'd0,
    REG_POINT_COUNT = 2'd1,
    REG_ARG_MAX     = 2'd2
  } reg_idx_t;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [NCOEF-1:0][DATA_W-1:0] coef_set_t;

  typedef struct packed {
    logic [ARG_W-1:0] inv_step;
    logic [CNT_W-1:0] point_count;
    logic [ARG_W-1:0] arg_max;
  } cfg_t;

  // Per-request control that travels beside the coefficients
  typedef struct packed {
    logic              is_eval;
    logic              ext;
    logic [FRAC_W-1:0] f_q;
    logic [FRAC_W-1:0] f_m;
    logic [ARG_W-1:0]  diff;
  } eval_ctl_t;

  typedef struct packed {
    logic  ov;
    word_t val;
  } sat_t;

  // Clamp a wide signed value to 32 bits and flag the clamp
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t res;
    if (v > SAT_HI) begin
      res.ov  = 1'b1;
      res.val = word_t'(SAT_HI[DATA_W-1:0]);
    end else if (v < SAT_LO) begin
      res.ov  = 1'b1;
      res.val = word_t'(SAT_LO[DATA_W-1:0]);
    end else begin
      res.ov  = 1'b0;
      res.val = word_t'(v[DATA_W-1:0]);
    end
    return res;
  endfunction

  // One Horner step: floor(acc*f / 2^16) + c, saturated
  function automatic sat_t horner(input word_t acc, input logic [FRAC_W-1:0] f,
                                  input word_t c);
    logic signed [DATA_W+FRAC_W:0] prod;
    logic signed [63:0]            sum;
    prod = (DATA_W+FRAC_W+1)'(acc) * $signed({1'b0, f});
    sum  = 64'(prod >>> 16) + 64'(c);
    return sat32(sum);
  endfunction

endpackage

FILE: hdl/tabulated_spline_function_evaluator.sv
// Throughput 1 request/cycle while out_stall is low; a stalled output holds the pipeline and raises in_stall.
// Stages: capture+pair map, scale multiply, cell select, coefficient RAM read, three Horner
// multiply-accumulate stages (the extension multiply shares the third), extension add/output.
// Reset clears pipeline valid bits, sets registers to defaults and zeroes the pair map;
// the coefficient RAM is not cleared and holds garbage until written.
module tabulated_spline_function_evaluator import tsfe_pkg::*; #(
  parameter int MAX_TABLES = DEF_MAX_TABLES,
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int MAX_TYPES  = DEF_MAX_TYPES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [TYPE_W-1:0]        in_type_i,
  input  logic [TYPE_W-1:0]        in_type_j,
  input  logic [TAB_W-1:0]         in_table_index,
  input  logic [PT_W-1:0]          in_point_index,
  input  logic [SLOT_W-1:0]        in_coeff_slot,
  input  logic signed [DATA_W-1:0] in_write_word,
  input  logic [ARG_W-1:0]         in_query_arg,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_value_out,
  output logic signed [DATA_W-1:0] out_slope_out,
  output logic                     out_overflowed
);

  cfg_t      cfg;
  logic      mid_valid;
  logic      mid_stall;
  eval_ctl_t mid_ctl;
  coef_set_t mid_coef_q;
  coef_set_t mid_coef_m;

  // Configuration registers
  tsfe_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Capture, scale, select cell, fetch coefficients
  tsfe_front #(
    .MAX_TABLES (MAX_TABLES),
    .MAX_POINTS (MAX_POINTS),
    .MAX_TYPES  (MAX_TYPES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_type_i      (in_type_i),
    .in_type_j      (in_type_j),
    .in_table_index (in_table_index),
    .in_point_index (in_point_index),
    .in_coeff_slot  (in_coeff_slot),
    .in_write_word  (in_write_word),
    .in_query_arg   (in_query_arg),
    .dn_valid       (mid_valid),
    .dn_stall       (mid_stall),
    .dn_ctl         (mid_ctl),
    .dn_coef_q      (mid_coef_q),
    .dn_coef_m      (mid_coef_m)
  );

  // Horner evaluation and extension
  tsfe_eval u_eval (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (mid_valid),
    .up_stall       (mid_stall),
    .up_ctl         (mid_ctl),
    .up_coef_q      (mid_coef_q),
    .up_coef_m      (mid_coef_m),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value_out  (out_value_out),
    .out_slope_out  (out_slope_out),
    .out_overflowed (out_overflowed)
  );

endmodule

FILE: hdl/tsfe_regs.sv
// APB-style configuration registers of the spline evaluator.
// Depends on tsfe_pkg for register indexes, widths and reset values.
module tsfe_regs import tsfe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t     cfg_r;
  reg_idx_t reg_idx;

  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_step    <= INV_STEP_RST;
      cfg_r.point_count <= POINT_COUNT_RST;
      cfg_r.arg_max     <= ARG_MAX_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_INV_STEP:    cfg_r.inv_step    <= pwdata[ARG_W-1:0];
        REG_POINT_COUNT: cfg_r.point_count <= pwdata[CNT_W-1:0];
        REG_ARG_MAX:     cfg_r.arg_max     <= pwdata[ARG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_INV_STEP:    prdata = 32'(cfg_r.inv_step);
      REG_POINT_COUNT: prdata = 32'(cfg_r.point_count);
      REG_ARG_MAX:     prdata = 32'(cfg_r.arg_max);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: hdl/tsfe_ram.sv
// One coefficient bank: one write port, two read ports with registered data.
// Depends on tsfe_pkg for the word width.
module tsfe_ram import tsfe_pkg::*; #(
  parameter int DEPTH = DEF_MAX_TABLES * DEF_MAX_POINTS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [DATA_W-1:0]        rdata_a,
  output logic [DATA_W-1:0]        rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;

  // Write, and read both ports when the next stage takes data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

FILE: hdl/tsfe_front.sv
// Front end: request capture, pair map, argument scaling, cell select and coefficient fetch.
// Depends on tsfe_pkg and tsfe_ram; feeds tsfe_eval with coefficients and control.
module tsfe_front import tsfe_pkg::*; #(
  parameter int MAX_TABLES = DEF_MAX_TABLES,
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int MAX_TYPES  = DEF_MAX_TYPES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [TYPE_W-1:0]        in_type_i,
  input  logic [TYPE_W-1:0]        in_type_j,
  input  logic [TAB_W-1:0]         in_table_index,
  input  logic [PT_W-1:0]          in_point_index,
  input  logic [SLOT_W-1:0]        in_coeff_slot,
  input  logic signed [DATA_W-1:0] in_write_word,
  input  logic [ARG_W-1:0]         in_query_arg,
  output logic                     dn_valid,
  input  logic                     dn_stall,
  output eval_ctl_t                dn_ctl,
  output coef_set_t                dn_coef_q,
  output coef_set_t                dn_coef_m
);

  localparam int DEPTH     = MAX_TABLES * MAX_POINTS;
  localparam int AW        = $clog2(DEPTH);
  localparam int PIW       = $clog2(MAX_POINTS);
  localparam int CW        = (CNT_W > PIW + 1) ? CNT_W : PIW + 1;
  localparam int MAP_DEPTH = MAX_TYPES * MAX_TYPES;
  localparam int MIW       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  typedef struct packed {
    logic [PIW-1:0]    mm1;
    logic [FRAC_W-1:0] frac;
  } cell_t;

  // Cell index minus one and fraction from the scaled argument
  function automatic cell_t cell_pick(input logic [PROD_W-1:0] prod,
                                      input logic [PIW-1:0] lim);
    cell_t res;
    if (prod[PROD_W-1:32] >= (PROD_W-32)'(lim)) begin
      res.mm1  = lim - PIW'(1);
      res.frac = ONE_Q;
    end else begin
      res.mm1  = PIW'(prod[PROD_W-1:32]);
      res.frac = {1'b0, prod[31:16]};
    end
    return res;
  endfunction

  // Stage handshake
  logic v_a_r, v_b_r, v_c_r, v_d_r;
  logic load_a, load_b, load_c, load_d;

  // Input decode
  cmd_t           cmd_in;
  logic           coef_ok, types_ok, tab_ok;
  logic           is_eval_nxt, wr_en_nxt, map_we;
  logic [MIW-1:0] map_idx;
  logic [AW-1:0]  wr_addr_nxt;
  logic [TAB_W-1:0] tab_lkp;
  logic [TAB_W-1:0] map_r [MAP_DEPTH];

  // Stage A
  logic              is_eval_a_r, wr_en_a_r;
  logic [SLOT_W-1:0] wr_slot_a_r;
  logic [AW-1:0]     wr_addr_a_r;
  logic [DATA_W-1:0] wr_data_a_r;
  logic [TAB_W-1:0]  tab_a_r;
  logic [ARG_W-1:0]  q_a_r;

  // Stage B
  logic [PROD_W-1:0] prod_q_nxt, prod_m_nxt;
  logic [PROD_W-1:0] prod_q_b_r, prod_m_b_r;
  logic              is_eval_b_r, wr_en_b_r, ext_b_r;
  logic [SLOT_W-1:0] wr_slot_b_r;
  logic [AW-1:0]     wr_addr_b_r;
  logic [DATA_W-1:0] wr_data_b_r;
  logic [TAB_W-1:0]  tab_b_r;
  logic [ARG_W-1:0]  diff_b_r;

  // Stage C
  logic [CW-1:0]     pc_w;
  logic [PIW-1:0]    nm1;
  cell_t             cell_q, cell_m;
  logic [AW-1:0]     addr_q_nxt, addr_m_nxt;
  logic [AW-1:0]     addr_q_c_r, addr_m_c_r;
  eval_ctl_t         ctl_c_r;
  logic              wr_en_c_r;
  logic [SLOT_W-1:0] wr_slot_c_r;
  logic [AW-1:0]     wr_addr_c_r;
  logic [DATA_W-1:0] wr_data_c_r;

  // Stage D
  eval_ctl_t         ctl_d_r;
  logic [NCOEF-1:0]  bank_we;

  assign load_d   = !v_d_r || !dn_stall;
  assign load_c   = !v_c_r || load_d;
  assign load_b   = !v_b_r || load_c;
  assign load_a   = !v_a_r || load_b;
  assign in_stall = !load_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else begin
      if (load_a) v_a_r <= in_valid;
      if (load_b) v_b_r <= v_a_r;
      if (load_c) v_c_r <= v_b_r;
      if (load_d) v_d_r <= v_c_r;
    end
  end

  // Decode the incoming request
  assign cmd_in   = cmd_t'(in_cmd);
  assign tab_ok   = int'(in_table_index) < MAX_TABLES;
  assign types_ok = (int'(in_type_i) < MAX_TYPES) && (int'(in_type_j) < MAX_TYPES);
  assign coef_ok  = (int'(in_point_index) >= 1) && (int'(in_point_index) <= MAX_POINTS) &&
                    (in_coeff_slot < SLOT_W'(NCOEF)) && tab_ok;
  assign map_idx  = MIW'(int'(in_type_i) * MAX_TYPES + int'(in_type_j));
  assign wr_addr_nxt = AW'(int'(in_table_index) * MAX_POINTS + int'(in_point_index) - 1);
  assign tab_lkp  = types_ok ? map_r[map_idx] : '0;

  always_comb begin
    is_eval_nxt = 1'b0;
    wr_en_nxt   = 1'b0;
    map_we      = 1'b0;
    case (cmd_in)
      CMD_WCOEF: wr_en_nxt   = coef_ok;
      CMD_WMAP:  map_we      = types_ok && tab_ok;
      CMD_EVAL:  is_eval_nxt = 1'b1;
      default: ;
    endcase
  end

  // Pair map: written and read at acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAP_DEPTH; k++) begin
        map_r[k] <= '0;
      end
    end else if (in_valid && load_a && map_we) begin
      map_r[map_idx] <= in_table_index;
    end
  end

  // Stage A: capture
  always_ff @(posedge clk) begin
    if (load_a) begin
      is_eval_a_r <= is_eval_nxt;
      wr_en_a_r   <= wr_en_nxt;
      wr_slot_a_r <= in_coeff_slot;
      wr_addr_a_r <= wr_addr_nxt;
      wr_data_a_r <= in_write_word;
      tab_a_r     <= tab_lkp;
      q_a_r       <= in_query_arg;
    end
  end

  // Stage B: scale argument and maximum by the inverse step
  assign prod_q_nxt = PROD_W'(q_a_r) * PROD_W'(cfg.inv_step);
  assign prod_m_nxt = PROD_W'(cfg.arg_max) * PROD_W'(cfg.inv_step);

  always_ff @(posedge clk) begin
    if (load_b) begin
      prod_q_b_r  <= prod_q_nxt;
      prod_m_b_r  <= prod_m_nxt;
      ext_b_r     <= q_a_r > cfg.arg_max;
      diff_b_r    <= q_a_r - cfg.arg_max;
      is_eval_b_r <= is_eval_a_r;
      wr_en_b_r   <= wr_en_a_r;
      wr_slot_b_r <= wr_slot_a_r;
      wr_addr_b_r <= wr_addr_a_r;
      wr_data_b_r <= wr_data_a_r;
      tab_b_r     <= tab_a_r;
    end
  end

  // Stage C: clamp point count, pick cells, form bank addresses
  always_comb begin
    pc_w = CW'(cfg.point_count);
    if (pc_w < CW'(2)) begin
      nm1 = PIW'(1);
    end else if (pc_w > CW'(MAX_POINTS)) begin
      nm1 = PIW'(MAX_POINTS - 1);
    end else begin
      nm1 = PIW'(pc_w - CW'(1));
    end
  end

  assign cell_q     = cell_pick(prod_q_b_r, nm1);
  assign cell_m     = cell_pick(prod_m_b_r, nm1);
  assign addr_q_nxt = AW'(int'(tab_b_r) * MAX_POINTS + int'(cell_q.mm1));
  assign addr_m_nxt = AW'(int'(tab_b_r) * MAX_POINTS + int'(cell_m.mm1));

  always_ff @(posedge clk) begin
    if (load_c) begin
      addr_q_c_r      <= addr_q_nxt;
      addr_m_c_r      <= addr_m_nxt;
      ctl_c_r.is_eval <= is_eval_b_r;
      ctl_c_r.ext     <= ext_b_r;
      ctl_c_r.f_q     <= cell_q.frac;
      ctl_c_r.f_m     <= cell_m.frac;
      ctl_c_r.diff    <= diff_b_r;
      wr_en_c_r       <= wr_en_b_r;
      wr_slot_c_r     <= wr_slot_b_r;
      wr_addr_c_r     <= wr_addr_b_r;
      wr_data_c_r     <= wr_data_b_r;
    end
  end

  // Stage D: coefficient write and fetch move together, keeping request order
  always_comb begin
    for (int k = 0; k < NCOEF; k++) begin
      bank_we[k] = v_c_r && wr_en_c_r && load_d && (wr_slot_c_r == SLOT_W'(k));
    end
  end

  for (genvar k = 0; k < NCOEF; k++) begin : g_bank
    tsfe_ram #(
      .DEPTH(DEPTH)
    ) u_ram (
      .clk     (clk),
      .we      (bank_we[k]),
      .waddr   (wr_addr_c_r),
      .wdata   (wr_data_c_r),
      .re      (load_d),
      .raddr_a (addr_q_c_r),
      .raddr_b (addr_m_c_r),
      .rdata_a (dn_coef_q[k]),
      .rdata_b (dn_coef_m[k])
    );
  end

  always_ff @(posedge clk) begin
    if (load_d) begin
      ctl_d_r <= ctl_c_r;
    end
  end

  assign dn_valid = v_d_r;
  assign dn_ctl   = ctl_d_r;

  // A stalled fetch keeps its slot
  a_hold_d: assert property (@(posedge clk) disable iff (!rst_n)
    v_d_r && dn_stall |=> v_d_r)
    else $error("fetched request dropped while stalled");

  // Fractions never exceed one
  a_frac: assert property (@(posedge clk) disable iff (!rst_n)
    v_c_r && ctl_c_r.is_eval |-> (ctl_c_r.f_q <= ONE_Q) && (ctl_c_r.f_m <= ONE_Q))
    else $error("cell fraction above one");

  // Lookup addresses stay inside the tables
  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    v_c_r && ctl_c_r.is_eval |-> (int'(addr_q_c_r) < DEPTH) && (int'(addr_m_c_r) < DEPTH))
    else $error("coefficient address out of range");

endmodule

FILE: hdl/tsfe_eval.sv
// Evaluation pipeline: Horner steps for value and slope, linear extension, output register.
// Depends on tsfe_pkg for types and the saturating Horner helpers.
module tsfe_eval import tsfe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_stall,
  input  eval_ctl_t                up_ctl,
  input  coef_set_t                up_coef_q,
  input  coef_set_t                up_coef_m,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_value_out,
  output logic signed [DATA_W-1:0] out_slope_out,
  output logic                     out_overflowed
);

  logic v_e_r, v_f_r, v_g_r, v_h_r;
  logic load_e, load_f, load_g, load_h;

  // Stage E
  sat_t      hv_q1, hs_q1, hv_m1, hs_m1;
  eval_ctl_t ctl_e_r;
  word_t     accv_q_e_r, accs_q_e_r, accv_m_e_r, accs_m_e_r;
  word_t     c2q_e_r, c5q_e_r, c6q_e_r, c2m_e_r, c5m_e_r, c6m_e_r;
  logic      ovq_e_r, ovm_e_r;

  // Stage F
  sat_t      hv_q2, hs_q2, hv_m2, hs_m2;
  eval_ctl_t ctl_f_r;
  word_t     accv_q_f_r, slp_q_f_r, accv_m_f_r, slp_m_f_r, c6q_f_r, c6m_f_r;
  logic      ovq_f_r, ovm_f_r;

  // Stage G
  sat_t               hv_q3, hv_m3;
  logic signed [63:0] prodx_nxt;
  eval_ctl_t          ctl_g_r;
  word_t              val_q_g_r, slp_q_g_r;
  logic signed [63:0] prodx_g_r;
  logic               ovq_g_r, ovm_g_r;

  // Stage H
  sat_t  term, ext_sum;
  word_t value_nxt;
  logic  ov_nxt;
  word_t out_value_r, out_slope_r;
  logic  out_ov_r;

  assign load_h   = !v_h_r || !out_stall;
  assign load_g   = !v_g_r || load_h;
  assign load_f   = !v_f_r || load_g;
  assign load_e   = !v_e_r || load_f;
  assign up_stall = !load_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_e_r <= 1'b0;
      v_f_r <= 1'b0;
      v_g_r <= 1'b0;
      v_h_r <= 1'b0;
    end else begin
      if (load_e) v_e_r <= up_valid;
      if (load_f) v_f_r <= v_e_r;
      if (load_g) v_g_r <= v_f_r;
      if (load_h) v_h_r <= v_g_r;
    end
  end

  // Stage E: first Horner step at the argument and at the maximum
  assign hv_q1 = horner($signed(up_coef_q[3]), up_ctl.f_q, $signed(up_coef_q[4]));
  assign hs_q1 = horner($signed(up_coef_q[0]), up_ctl.f_q, $signed(up_coef_q[1]));
  assign hv_m1 = horner($signed(up_coef_m[3]), up_ctl.f_m, $signed(up_coef_m[4]));
  assign hs_m1 = horner($signed(up_coef_m[0]), up_ctl.f_m, $signed(up_coef_m[1]));

  always_ff @(posedge clk) begin
    if (load_e) begin
      ctl_e_r    <= up_ctl;
      accv_q_e_r <= hv_q1.val;
      accs_q_e_r <= hs_q1.val;
      accv_m_e_r <= hv_m1.val;
      accs_m_e_r <= hs_m1.val;
      ovq_e_r    <= hv_q1.ov | hs_q1.ov;
      ovm_e_r    <= hv_m1.ov | hs_m1.ov;
      c2q_e_r    <= $signed(up_coef_q[2]);
      c5q_e_r    <= $signed(up_coef_q[5]);
      c6q_e_r    <= $signed(up_coef_q[6]);
      c2m_e_r    <= $signed(up_coef_m[2]);
      c5m_e_r    <= $signed(up_coef_m[5]);
      c6m_e_r    <= $signed(up_coef_m[6]);
    end
  end

  // Stage F: second step; slopes finish here
  assign hv_q2 = horner(accv_q_e_r, ctl_e_r.f_q, c5q_e_r);
  assign hs_q2 = horner(accs_q_e_r, ctl_e_r.f_q, c2q_e_r);
  assign hv_m2 = horner(accv_m_e_r, ctl_e_r.f_m, c5m_e_r);
  assign hs_m2 = horner(accs_m_e_r, ctl_e_r.f_m, c2m_e_r);

  always_ff @(posedge clk) begin
    if (load_f) begin
      ctl_f_r    <= ctl_e_r;
      accv_q_f_r <= hv_q2.val;
      slp_q_f_r  <= hs_q2.val;
      accv_m_f_r <= hv_m2.val;
      slp_m_f_r  <= hs_m2.val;
      ovq_f_r    <= ovq_e_r | hv_q2.ov | hs_q2.ov;
      ovm_f_r    <= ovm_e_r | hv_m2.ov | hs_m2.ov;
      c6q_f_r    <= c6q_e_r;
      c6m_f_r    <= c6m_e_r;
    end
  end

  // Stage G: last value step and the extension product
  assign hv_q3     = horner(accv_q_f_r, ctl_f_r.f_q, c6q_f_r);
  assign hv_m3     = horner(accv_m_f_r, ctl_f_r.f_m, c6m_f_r);
  assign prodx_nxt = 64'(slp_m_f_r) * $signed({33'b0, ctl_f_r.diff});

  always_ff @(posedge clk) begin
    if (load_g) begin
      ctl_g_r   <= ctl_f_r;
      val_q_g_r <= hv_q3.val;
      slp_q_g_r <= slp_q_f_r;
      prodx_g_r <= prodx_nxt;
      ovq_g_r   <= ovq_f_r | hv_q3.ov;
      ovm_g_r   <= ovm_f_r | hv_m3.ov;
    end
  end

  // Stage H: add the extension above the maximum, zero non-evaluate results
  assign term    = sat32(prodx_g_r >>> 16);
  assign ext_sum = sat32(64'(val_q_g_r) + 64'(term.val));

  always_comb begin
    if (!ctl_g_r.is_eval) begin
      value_nxt = '0;
      ov_nxt    = 1'b0;
    end else if (ctl_g_r.ext) begin
      value_nxt = ext_sum.val;
      ov_nxt    = ovq_g_r | ovm_g_r | term.ov | ext_sum.ov;
    end else begin
      value_nxt = val_q_g_r;
      ov_nxt    = ovq_g_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_h) begin
      out_value_r <= value_nxt;
      out_slope_r <= ctl_g_r.is_eval ? slp_q_g_r : word_t'(0);
      out_ov_r    <= ov_nxt;
    end
  end

  assign out_valid      = v_h_r;
  assign out_value_out  = out_value_r;
  assign out_slope_out  = out_slope_r;
  assign out_overflowed = out_ov_r;

  // Write and unknown requests leave all-zero results
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v_g_r && !ctl_g_r.is_eval && load_h |=>
      (out_value_out == '0) && (out_slope_out == '0) && !out_overflowed)
    else $error("non-evaluate request produced a nonzero result");

  // A stalled first Horner stage keeps its request
  a_hold_e: assert property (@(posedge clk) disable iff (!rst_n)
    v_e_r && !load_f |=> v_e_r && $stable(ctl_e_r))
    else $error("Horner stage lost a request while stalled");

  // A stalled result stays on the output
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

endmodule

FILE: verif/tabulated_spline_function_evaluator_tb.sv
// Self-checking testbench for tabulated_spline_function_evaluator: coefficient and map writes,
// spline evaluations with linear extension, checked against an in-bench Q16.16 predictor except on unfilled rows.
// Depends on tsfe_pkg (widths, command and register codes) and the evaluator RTL.
module tabulated_spline_function_evaluator_tb;
  import tsfe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_PCT = 36;
  localparam int FILL_ROWS = 8;
  localparam logic [ARG_W-1:0] ARG_TOP = {ARG_W{1'b1}};

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TYPE_W-1:0] type_i;
    logic [TYPE_W-1:0] type_j;
    logic [TAB_W-1:0]  table_index;
    logic [PT_W-1:0]   point_index;
    logic [SLOT_W-1:0] coeff_slot;
    word_t             write_word;
    logic [ARG_W-1:0]  query_arg;
  } spline_req_t;

  typedef struct packed {
    word_t value;
    word_t slope;
    logic  ovf;
    logic  chk;
  } spline_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [TYPE_W-1:0] in_type_i = '0;
  logic [TYPE_W-1:0] in_type_j = '0;
  logic [TAB_W-1:0] in_table_index = '0;
  logic [PT_W-1:0] in_point_index = '0;
  logic [SLOT_W-1:0] in_coeff_slot = '0;
  logic signed [DATA_W-1:0] in_write_word = '0;
  logic [ARG_W-1:0] in_query_arg = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_value_out;
  logic signed [DATA_W-1:0] out_slope_out;
  logic out_overflowed;

  tabulated_spline_function_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_type_i(in_type_i), .in_type_j(in_type_j), .in_table_index(in_table_index),
    .in_point_index(in_point_index), .in_coeff_slot(in_coeff_slot),
    .in_write_word(in_write_word), .in_query_arg(in_query_arg),
    .out_valid(out_valid), .out_stall(out_stall), .out_value_out(out_value_out),
    .out_slope_out(out_slope_out), .out_overflowed(out_overflowed)
  );

  // Shadow of the block: coefficient store, written marks, pair map and registers
  word_t            coef_mem [DEF_MAX_TABLES][DEF_MAX_POINTS][NCOEF];
  logic [NCOEF-1:0] coef_set [DEF_MAX_TABLES][DEF_MAX_POINTS];
  logic [TAB_W-1:0] pair_tab [DEF_MAX_TYPES][DEF_MAX_TYPES];
  logic [ARG_W-1:0] cfg_inv = INV_STEP_RST;
  logic [CNT_W-1:0] cfg_points = POINT_COUNT_RST;
  logic [ARG_W-1:0] cfg_arg_max = ARG_MAX_RST;

  spline_req_t    pending_requests [$];
  spline_result_t expected_results [$];
  int  requests_queued = 0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  int  eval_count = 0;
  int  ext_count = 0;
  int  sat_count = 0;
  int  unchecked_count = 0;
  int  settings_count = 0;
  int  idle_pct = IDLE_PCT;
  bit  sat_seen;
  logic req_taken = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    if (mismatch_count < 100) $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Saturate to signed 32 bits, remembering that a clamp happened
  function automatic word_t q16_clamp(input longint v);
    if (v > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return 32'sh80000000;
    end
    return word_t'(v[31:0]);
  endfunction

  // acc*f floored to Q16.16, plus c
  function automatic word_t horner_q16(input word_t acc, input logic [FRAC_W-1:0] f,
                                       input word_t c);
    longint prod;
    prod = longint'(acc) * longint'({47'b0, f});
    return q16_clamp((prod >>> 16) + longint'(c));
  endfunction

  // Cell select and both Horner chains for one argument; flag rows never fully written
  task automatic spline_lookup(input logic [TAB_W-1:0] t, input logic [ARG_W-1:0] a,
                               output word_t v, output word_t s, output bit known);
    logic [63:0] n, p, m, f;
    logic [9:0] row;
    word_t acc;
    n = 64'(cfg_points);
    if (n < 64'd2) n = 64'd2;
    if (n > 64'(DEF_MAX_POINTS)) n = 64'(DEF_MAX_POINTS);
    p = ((64'(a) * 64'(cfg_inv)) >> 16) + 64'd65536;
    m = p >> 16;
    if (m > n - 64'd1) m = n - 64'd1;
    if (m < 64'd1) m = 64'd1;
    f = p - (m << 16);
    if (f > 64'd65536) f = 64'd65536;
    row = 10'(m - 64'd1);
    known = &coef_set[t][row];
    acc = horner_q16(coef_mem[t][row][3], f[FRAC_W-1:0], coef_mem[t][row][4]);
    acc = horner_q16(acc, f[FRAC_W-1:0], coef_mem[t][row][5]);
    v = horner_q16(acc, f[FRAC_W-1:0], coef_mem[t][row][6]);
    acc = horner_q16(coef_mem[t][row][0], f[FRAC_W-1:0], coef_mem[t][row][1]);
    s = horner_q16(acc, f[FRAC_W-1:0], coef_mem[t][row][2]);
  endtask

  // Update the shadow for one accepted request and queue its result
  task automatic predict_request(input spline_req_t r);
    spline_result_t e;
    logic [TAB_W-1:0] t;
    word_t vm, sm;
    longint term;
    bit known_q, known_m;
    e = '0;
    e.chk = 1'b1;
    sat_seen = 1'b0;
    case (r.cmd)
      CMD_WCOEF: begin
        if (r.point_index >= 1 && r.point_index <= DEF_MAX_POINTS && r.coeff_slot < NCOEF) begin
          coef_mem[r.table_index][10'(r.point_index - 1)][r.coeff_slot] = r.write_word;
          coef_set[r.table_index][10'(r.point_index - 1)][r.coeff_slot] = 1'b1;
        end
      end
      CMD_WMAP: pair_tab[r.type_i][r.type_j] = r.table_index;
      CMD_EVAL: begin
        t = pair_tab[r.type_i][r.type_j];
        known_m = 1'b1;
        spline_lookup(t, r.query_arg, e.value, e.slope, known_q);
        if (r.query_arg > cfg_arg_max) begin
          spline_lookup(t, cfg_arg_max, vm, sm, known_m);
          term = (longint'(sm) * longint'(64'(r.query_arg) - 64'(cfg_arg_max))) >>> 16;
          e.value = q16_clamp(longint'(e.value) + longint'(q16_clamp(term)));
          ext_count++;
        end
        e.ovf = sat_seen;
        e.chk = known_q && known_m;
        eval_count++;
        if (!e.chk) unchecked_count++;
        else if (sat_seen) sat_count++;
      end
      default: ;
    endcase
    expected_results.push_back(e);
  endtask

  // Request side: take a new request once the last one went through
  always @(negedge clk) begin : drive_requests
    spline_req_t nx;
    if (rst_n && (!in_valid || req_taken)) begin
      if (pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        nx = pending_requests.pop_front();
        in_valid       <= 1'b1;
        in_cmd         <= nx.cmd;
        in_type_i      <= nx.type_i;
        in_type_j      <= nx.type_j;
        in_table_index <= nx.table_index;
        in_point_index <= nx.point_index;
        in_coeff_slot  <= nx.coeff_slot;
        in_write_word  <= nx.write_word;
        in_query_arg   <= nx.query_arg;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: stall at random
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < idle_pct);
  end

  // Predict each accepted request
  always @(posedge clk) begin
    req_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      predict_request('{in_cmd, in_type_i, in_type_j, in_table_index, in_point_index,
                        in_coeff_slot, in_write_word, in_query_arg});
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    spline_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: value %h slope %h ovf %b",
                                out_value_out, out_slope_out, out_overflowed));
      end else begin
        want = expected_results.pop_front();
        if (want.chk) begin
          if (out_value_out !== want.value)
            note_mismatch($sformatf("value_out %h, want %h", out_value_out, want.value));
          if (out_slope_out !== want.slope)
            note_mismatch($sformatf("slope_out %h, want %h", out_slope_out, want.slope));
          if (out_overflowed !== want.ovf)
            note_mismatch($sformatf("overflowed %b, want %b", out_overflowed, want.ovf));
        end
      end
    end
  end

  function automatic spline_req_t mk_req(input logic [CMD_W-1:0] cmd,
                                         input logic [TYPE_W-1:0] ti, input logic [TYPE_W-1:0] tj,
                                         input logic [TAB_W-1:0] tab, input logic [PT_W-1:0] pt,
                                         input logic [SLOT_W-1:0] slot, input word_t w,
                                         input logic [ARG_W-1:0] q);
    return '{cmd, ti, tj, tab, pt, slot, w, q};
  endfunction

  task automatic queue_request(input spline_req_t r);
    pending_requests.push_back(r);
    requests_queued++;
  endtask

  // Wait for every queued request to come back, then let the pipe settle
  task automatic drain();
    wait (results_seen >= requests_queued);
    repeat (20) @(posedge clk);
  endtask

  // Coefficients: mostly modest values, sometimes extremes or full range
  function automatic word_t pick_word();
    case ($urandom_range(0, 19))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return '0;
      3: return word_t'($urandom());
      default: return word_t'($urandom_range(0, 524288)) - 32'sd262144;
    endcase
  endfunction

  // Arguments: aim at filled cells and cell edges, at arg_max, and at the range ends
  function automatic logic [ARG_W-1:0] pick_query();
    logic [63:0] n, pp, qq;
    longint near;
    int unsigned m, fr;
    n = 64'(cfg_points);
    if (n < 64'd2) n = 64'd2;
    if (n > 64'(DEF_MAX_POINTS)) n = 64'(DEF_MAX_POINTS);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return ARG_TOP;
      2: return cfg_arg_max;
      3, 4: begin
        near = longint'(cfg_arg_max) + longint'($urandom_range(0, 4096)) - 64'sd2048;
        if (near < 0) return '0;
        if (near > longint'(ARG_TOP)) return ARG_TOP;
        return ARG_W'(near);
      end
      5: return ARG_W'($urandom());
      6: return ARG_W'($urandom_range(0, 1 << 20));
      default: begin
        if (n <= 64'(FILL_ROWS + 1)) m = $urandom_range(1, 32'(n));
        else if ($urandom_range(0, 3) == 0) m = $urandom_range(32'(n) - 1, 32'(n));
        else m = $urandom_range(1, FILL_ROWS);
        case ($urandom_range(0, 3))
          0: fr = 0;
          1: fr = 65535;
          default: fr = $urandom_range(0, 65535);
        endcase
        if (cfg_inv == '0) return ARG_W'($urandom());
        pp = (64'(m - 1) << 16) + 64'(fr);
        qq = (pp << 16) / 64'(cfg_inv);
        if (qq > 64'(ARG_TOP)) return ARG_TOP;
        return ARG_W'(qq);
      end
    endcase
  endfunction

  // Mostly evaluations, with writes, remaps and junk mixed in
  function automatic spline_req_t random_request();
    spline_req_t r;
    int unsigned k;
    r = mk_req(CMD_W'($urandom_range(0, 3)), TYPE_W'($urandom_range(0, 3)),
               TYPE_W'($urandom_range(0, 3)), TAB_W'($urandom_range(0, 3)),
               PT_W'($urandom_range(0, 2047)), SLOT_W'($urandom_range(0, 7)),
               word_t'($urandom()), ARG_W'($urandom()));
    k = $urandom_range(0, 99);
    if (k < 58) begin
      r.cmd = CMD_EVAL;
      r.query_arg = pick_query();
    end else if (k < 73) begin
      r.cmd = CMD_WCOEF;
      r.point_index = PT_W'($urandom_range(1, DEF_MAX_POINTS));
      r.coeff_slot = SLOT_W'($urandom_range(0, NCOEF - 1));
      r.write_word = pick_word();
    end else if (k < 87) begin
      r.cmd = CMD_WMAP;
    end else if (k < 93) begin
      r.cmd = CMD_UNUSED;
    end else begin
      // coefficient write that must be dropped
      r.cmd = CMD_WCOEF;
      case ($urandom_range(0, 2))
        0: r.point_index = '0;
        1: r.point_index = PT_W'($urandom_range(DEF_MAX_POINTS + 1, 2047));
        default: r.coeff_slot = SLOT_W'(NCOEF);
      endcase
    end
    return r;
  endfunction

  // Register write followed by a readback
  task automatic program_reg(input reg_idx_t idx, input logic [31:0] d);
    logic [31:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_INV_STEP:    cfg_inv = d[ARG_W-1:0];
      REG_POINT_COUNT: cfg_points = d[CNT_W-1:0];
      default:         cfg_arg_max = d[ARG_W-1:0];
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== d) note_mismatch($sformatf("register %s reads %h, wrote %h", idx.name(), rd, d));
  endtask

  // One register setting followed by a batch of random requests
  task automatic run_setting(input logic [ARG_W-1:0] inv, input logic [CNT_W-1:0] pts,
                             input logic [ARG_W-1:0] amax, input int count);
    program_reg(REG_INV_STEP, 32'(inv));
    program_reg(REG_POINT_COUNT, 32'(pts));
    program_reg(REG_ARG_MAX, 32'(amax));
    settings_count++;
    repeat (count) queue_request(random_request());
    drain();
  endtask

  initial begin : stimulus
    foreach (pair_tab[i, j]) pair_tab[i][j] = '0;
    foreach (coef_mem[t, p, s]) coef_mem[t][p][s] = '0;
    foreach (coef_set[t, p]) coef_set[t][p] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill the low rows and the top clamp row of every table
    for (int t = 0; t < DEF_MAX_TABLES; t++)
      for (int p = 1; p <= FILL_ROWS + 1; p++)
        for (int s = 0; s < NCOEF; s++)
          queue_request(mk_req(CMD_WCOEF, '0, '0, TAB_W'(t),
                               PT_W'((p > FILL_ROWS) ? DEF_MAX_POINTS - 1 : p),
                               SLOT_W'(s), pick_word(), '0));

    // Directed requests at reset settings (arg_max 0, so any nonzero argument extends)
    queue_request(mk_req(CMD_EVAL, 2'd0, 2'd0, '0, '0, '0, '0, '0));
    queue_request(mk_req(CMD_EVAL, 2'd1, 2'd2, '1, '1, '1, '1, ARG_W'(1)));
    queue_request(mk_req(CMD_EVAL, 2'd3, 2'd3, '0, '0, '0, '0, ARG_TOP));
    queue_request(mk_req(CMD_WCOEF, '0, '0, 2'd3, PT_W'(DEF_MAX_POINTS), SLOT_W'(6),
                         32'sh7FFFFFFF, '0));
    for (int s = 0; s < NCOEF; s++)
      queue_request(mk_req(CMD_WCOEF, '0, '0, 2'd2, PT_W'(1), SLOT_W'(s),
                           (s == 5) ? 32'sh80000000 : 32'sh7FFFFFFF, '0));
    queue_request(mk_req(CMD_WMAP, 2'd2, 2'd1, 2'd2, '0, '0, '0, '0));
    queue_request(mk_req(CMD_EVAL, 2'd2, 2'd1, '0, '0, '0, '0, '0));
    queue_request(mk_req(CMD_EVAL, 2'd2, 2'd1, '0, '0, '0, '0, ARG_W'(32768)));
    // dropped coefficient writes: point zero, past the table, slot seven
    queue_request(mk_req(CMD_WCOEF, '0, '0, 2'd2, '0, SLOT_W'(6), 32'sh12345678, '0));
    queue_request(mk_req(CMD_WCOEF, '0, '0, 2'd2, PT_W'(DEF_MAX_POINTS + 1), '0,
                         32'sh12345678, '0));
    queue_request(mk_req(CMD_WCOEF, '0, '0, 2'd2, '1, '0, 32'sh12345678, '0));
    queue_request(mk_req(CMD_WCOEF, '0, '0, 2'd2, PT_W'(1), '1, 32'sh12345678, '0));
    queue_request(mk_req(CMD_UNUSED, '1, '1, '1, '1, '1, '1, '1));
    queue_request(mk_req(CMD_WMAP, 2'd3, 2'd3, 2'd3, '0, '0, '0, '0));
    queue_request(mk_req(CMD_EVAL, 2'd3, 2'd3, '0, '0, '0, '0, ARG_W'(3 * 65536)));
    queue_request(mk_req(CMD_EVAL, 2'd2, 2'd1, '0, '0, '0, '0, ARG_TOP));
    drain();

    // Register settings, extremes first, then partly random ones and a full-table setting
    run_setting(ARG_W'(65536), CNT_W'(FILL_ROWS + 1), ARG_W'(15 * 65536), 150);
    run_setting(ARG_TOP, CNT_W'(DEF_MAX_POINTS), ARG_TOP, 120);
    run_setting('0, CNT_W'(2), '0, 80);
    run_setting(ARG_W'(1 << 20), '0, ARG_W'(5 * 65536), 80);
    idle_pct = 0;
    run_setting(ARG_W'(4096), '1, ARG_W'(100 * 65536), 200);
    idle_pct = IDLE_PCT;
    run_setting(ARG_W'(1 << 18), CNT_W'(1), ARG_W'($urandom()), 80);
    run_setting(ARG_W'($urandom()), CNT_W'($urandom_range(2, FILL_ROWS + 1)),
                ARG_W'($urandom()), 150);
    run_setting(ARG_W'(65536), CNT_W'(DEF_MAX_POINTS), ARG_W'(1023 * 65536), 160);

    if (expected_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("covered %0d requests over %0d register settings", requests_queued,
             settings_count);
    $display("%0d evaluations, %0d past arg_max, %0d saturated, %0d on unfilled rows, %0d mismatches",
             eval_count, ext_count, sat_count, unchecked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tabulated_spline_function_evaluator_tb: clean");
    end else begin
      $display("tabulated_spline_function_evaluator_tb: errors");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #20ms;
    $display("tabulated_spline_function_evaluator_tb: errors");
    $finish;
  end

endmodule
